@@ rtl/core/pdcs_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pdcs_pkg: shared types and constants of the definition scanner
// Scan modes, the handoff record between the front and back parts, and
// byte class helpers.
// ---------------------------------------------------------------------------
package pdcs_pkg;

  typedef enum logic [3:0] {
    M_START     = 4'd0,
    M_SKIP      = 4'd1,
    M_QUOTE     = 4'd2,
    M_QOPEN     = 4'd3,
    M_KW_CLASS  = 4'd4,
    M_KW_DEF    = 4'd5,
    M_WS_CLASS  = 4'd6,
    M_WS_DEF    = 4'd7,
    M_BUF_CLASS = 4'd8,
    M_BUF_DEF   = 4'd9
  } scan_mode_t;

  typedef enum logic [0:0] {
    B_IDLE = 1'b0,
    B_EMIT = 1'b1
  } back_state_t;

  localparam int unsigned LEN_W = 7;
  localparam int unsigned OUT_LINE_W = 24;

  // One found definition, passed from the front part to the back part.
  typedef struct packed {
    logic                  cls;
    logic [LEN_W-1:0]      len;
    logic [OUT_LINE_W-1:0] line;
  } job_t;

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'd32 || b == 8'd9 || b == 8'd13 || b == 8'd12 || b == 8'd11;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h61 && b <= 8'h7a) || b == 8'h5f;
  endfunction

  function automatic logic is_allowed(input logic [7:0] b);
    return is_word(b) || is_blank(b) || b == 8'h28 || b == 8'h29 ||
           b == 8'h2c || b == 8'h3d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/pdcs_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pdcs_if: valid/ready channel
// Carries one beat of payload of type T.
// ---------------------------------------------------------------------------
interface pdcs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pdcs_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pdcs_ram: generic single-write, single-read RAM
// Read data is registered.
// ---------------------------------------------------------------------------
module pdcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/pdcs_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pdcs_front: line scanner
// Tracks lines, quotes and keywords, writes candidate lines into the line
// store, and posts a job when a line is accepted.
// ---------------------------------------------------------------------------
module pdcs_front #(
  parameter int unsigned MAX_LINE  = 64,
  parameter int unsigned LINE_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_byte,
  input  wire logic                        in_eot,
  output logic                             job_valid,
  output pdcs_pkg::job_t                   job,
  input  wire logic                        job_ready,
  output logic                             we,
  output logic [$clog2(MAX_LINE)-1:0]      waddr,
  output logic [7:0]                       wdata
);
  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam int unsigned OLW = pdcs_pkg::OUT_LINE_W;
  localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

  pdcs_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic [2:0]             kw, kw_next;
  logic [1:0]             quote_run, quote_run_next;
  logic [LINE_BITS-1:0]   line_counter, line_counter_next;
  logic [pdcs_pkg::LEN_W-1:0] line_fill, line_fill_next;
  logic [pdcs_pkg::LEN_W-1:0] word_end_pos, word_end_pos_next;
  logic [pdcs_pkg::LEN_W-1:0] colon_pos, colon_pos_next;
  logic                   colon_seen, colon_seen_next;
  logic [LINE_BITS-1:0]   def_line, def_line_next;
  logic                   fire, emit;
  logic [pdcs_pkg::LEN_W-1:0] len;
  logic                   cls;

  assign fire = in_valid && in_ready;

  always_comb begin
    logic [7:0] b;
    logic       inc;
    logic       buf_now;
    logic [pdcs_pkg::LEN_W-1:0] i;
    b = in_byte;
    inc = 1'b0;
    buf_now = 1'b0;
    scan_mode_next = scan_mode;
    kw_next = kw;
    quote_run_next = quote_run;
    line_fill_next = line_fill;
    word_end_pos_next = word_end_pos;
    colon_pos_next = colon_pos;
    colon_seen_next = colon_seen;
    def_line_next = def_line;
    emit = 1'b0;
    we = 1'b0;
    i = line_fill;
    case (scan_mode)
      pdcs_pkg::M_START: begin
        if (b == 8'd10) begin
          inc = 1'b1;
        end else if (pdcs_pkg::is_blank(b)) begin
          scan_mode_next = pdcs_pkg::M_START;
        end else if (b == 8'h22) begin
          scan_mode_next = pdcs_pkg::M_QOPEN;
          quote_run_next = 2'd1;
        end else if (b == 8'h63) begin
          scan_mode_next = pdcs_pkg::M_KW_CLASS;
          kw_next = 3'd1;
        end else if (b == 8'h64) begin
          scan_mode_next = pdcs_pkg::M_KW_DEF;
          kw_next = 3'd1;
        end else begin
          scan_mode_next = pdcs_pkg::M_SKIP;
        end
      end
      pdcs_pkg::M_SKIP: begin
        if (b == 8'd10) begin
          inc = 1'b1;
          scan_mode_next = pdcs_pkg::M_START;
        end
      end
      pdcs_pkg::M_QUOTE: begin
        if (b == 8'h22) begin
          if (quote_run >= 2'd2) begin
            quote_run_next = 2'd0;
            scan_mode_next = pdcs_pkg::M_START;
          end else begin
            quote_run_next = quote_run + 2'd1;
          end
        end else begin
          quote_run_next = 2'd0;
          inc = (b == 8'd10);
        end
      end
      pdcs_pkg::M_QOPEN: begin
        if (b == 8'h22) begin
          if (quote_run >= 2'd2) begin
            quote_run_next = 2'd0;
            scan_mode_next = pdcs_pkg::M_QUOTE;
          end else begin
            quote_run_next = quote_run + 2'd1;
          end
        end else begin
          quote_run_next = 2'd0;
          inc = (b == 8'd10);
          scan_mode_next = (b == 8'd10) ? pdcs_pkg::M_START : pdcs_pkg::M_SKIP;
        end
      end
      pdcs_pkg::M_KW_CLASS, pdcs_pkg::M_KW_DEF: begin
        logic       c;
        logic [7:0] exp_b;
        c = (scan_mode == pdcs_pkg::M_KW_CLASS);
        case (kw)
          3'd1:    exp_b = c ? 8'h6c : 8'h65;
          3'd2:    exp_b = c ? 8'h61 : 8'h66;
          3'd3:    exp_b = 8'h73;
          default: exp_b = 8'h73;
        endcase
        if (kw >= (c ? 3'd5 : 3'd3)) begin
          kw_next = 3'd0;
          if (pdcs_pkg::is_blank(b)) begin
            scan_mode_next = c ? pdcs_pkg::M_WS_CLASS : pdcs_pkg::M_WS_DEF;
          end else begin
            inc = (b == 8'd10);
            scan_mode_next = (b == 8'd10) ? pdcs_pkg::M_START : pdcs_pkg::M_SKIP;
          end
        end else if (b == exp_b) begin
          kw_next = kw + 3'd1;
        end else begin
          kw_next = 3'd0;
          inc = (b == 8'd10);
          scan_mode_next = (b == 8'd10) ? pdcs_pkg::M_START : pdcs_pkg::M_SKIP;
        end
      end
      pdcs_pkg::M_WS_CLASS, pdcs_pkg::M_WS_DEF: begin
        if (pdcs_pkg::is_blank(b)) begin
          scan_mode_next = scan_mode;
        end else if (b == 8'd10) begin
          inc = 1'b1;
          scan_mode_next = pdcs_pkg::M_START;
        end else begin
          scan_mode_next = (scan_mode == pdcs_pkg::M_WS_CLASS) ?
                           pdcs_pkg::M_BUF_CLASS : pdcs_pkg::M_BUF_DEF;
          i = '0;
          word_end_pos_next = '0;
          colon_pos_next = '0;
          colon_seen_next = 1'b0;
          kw_next = 3'd0;
          def_line_next = line_counter;
          buf_now = 1'b1;
        end
      end
      pdcs_pkg::M_BUF_CLASS, pdcs_pkg::M_BUF_DEF: begin
        if (b == 8'd10) begin
          emit = colon_seen;
          inc = 1'b1;
          scan_mode_next = pdcs_pkg::M_START;
        end else begin
          buf_now = 1'b1;
        end
      end
      default: scan_mode_next = pdcs_pkg::M_START;
    endcase
    if (buf_now) begin
      if (32'(i) + 32'd1 >= MAX_LINE) begin
        scan_mode_next = pdcs_pkg::M_SKIP;
      end else begin
        we = 1'b1;
        line_fill_next = i + 1'b1;
        if (!colon_seen_next) begin
          logic go;
          go = 1'b1;
          if (kw_next == 3'd0) begin
            if (pdcs_pkg::is_word(b)) begin
              go = 1'b0;
            end else begin
              kw_next = 3'd1;
              word_end_pos_next = i;
            end
          end
          if (go && !pdcs_pkg::is_allowed(b)) begin
            if (b == 8'h3a) begin
              colon_seen_next = 1'b1;
              colon_pos_next = i;
            end else begin
              scan_mode_next = pdcs_pkg::M_SKIP;
            end
          end
        end
      end
    end
    if (in_eot && (scan_mode_next == pdcs_pkg::M_BUF_CLASS ||
                   scan_mode_next == pdcs_pkg::M_BUF_DEF)) begin
      emit = colon_seen_next;
    end
    cls = (scan_mode_next == pdcs_pkg::M_BUF_CLASS) ||
          (scan_mode == pdcs_pkg::M_BUF_CLASS && b == 8'd10);
    len = cls ? word_end_pos_next : colon_pos_next;
    if (32'(len) > MAX_LINE - 1) begin
      len = pdcs_pkg::LEN_W'(MAX_LINE - 1);
    end
    line_counter_next = (inc && line_counter < LINE_TOP) ?
                        line_counter + 1'b1 : line_counter;
    waddr = i[AW-1:0];
    wdata = b;
  end

  // The store holds one line, so the scanner only moves while the queue
  // and the back part can take a new job.
  assign in_ready = job_ready;
  assign job_valid = in_valid && emit;
  assign job.cls = cls;
  assign job.len = len;
  assign job.line = OLW'(def_line_next);

  always_ff @(posedge clk) begin
    if (rst || (fire && in_eot)) begin
      scan_mode <= pdcs_pkg::M_START;
      kw <= 3'd0;
      quote_run <= 2'd0;
      line_counter <= LINE_BITS'(1);
      line_fill <= '0;
      word_end_pos <= '0;
      colon_pos <= '0;
      colon_seen <= 1'b0;
      def_line <= '0;
    end else if (fire) begin
      scan_mode <= scan_mode_next;
      kw <= kw_next;
      quote_run <= quote_run_next;
      line_counter <= line_counter_next;
      line_fill <= line_fill_next;
      word_end_pos <= word_end_pos_next;
      colon_pos <= colon_pos_next;
      colon_seen <= colon_seen_next;
      def_line <= def_line_next;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/pdcs_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pdcs_back: name emitter
// Takes a job from the queue and reads the name out of the line store one
// character per beat.
// ---------------------------------------------------------------------------
module pdcs_back #(
  parameter int unsigned MAX_LINE = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   job_valid,
  input  pdcs_pkg::job_t              job,
  output logic                        job_ready,
  output logic [$clog2(MAX_LINE)-1:0] raddr,
  input  wire logic [7:0]             rdata,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  name_char,
  output logic                        char_valid,
  output logic                        is_class,
  output logic [23:0]                 start_line,
  output logic                        last_char
);
  localparam int unsigned AW = $clog2(MAX_LINE);

  pdcs_pkg::back_state_t state, state_next;
  pdcs_pkg::job_t        cur;
  logic [pdcs_pkg::LEN_W-1:0] idx, idx_next;
  logic                  rd_ok;
  logic                  take;

  assign take = job_valid && job_ready;

  always_comb begin
    state_next = state;
    case (state)
      pdcs_pkg::B_IDLE: if (job_valid) state_next = pdcs_pkg::B_EMIT;
      pdcs_pkg::B_EMIT: if (out_valid && out_ready && last_char)
                          state_next = pdcs_pkg::B_IDLE;
      default: state_next = pdcs_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == pdcs_pkg::B_IDLE);
    idx_next = idx;
    if (take) begin
      idx_next = '0;
    end else if (out_valid && out_ready) begin
      idx_next = idx + 1'b1;
    end
    raddr = idx_next[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdcs_pkg::B_IDLE;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      rd_ok <= (state_next == pdcs_pkg::B_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (take) begin
      cur <= job;
    end
  end

  assign out_valid = (state == pdcs_pkg::B_EMIT) && rd_ok;
  assign char_valid = (cur.len != '0);
  assign name_char = char_valid ? rdata : 8'd0;
  assign is_class = cur.cls;
  assign start_line = cur.line;
  assign last_char = (cur.len == '0) || (idx + 1'b1 == cur.len);

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_char |=> state == pdcs_pkg::B_IDLE)
    else $error("emitter did not return to idle after last beat");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> idx < cur.len)
    else $error("read index past name length");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state == pdcs_pkg::B_EMIT |-> !job_ready)
    else $error("job taken while emitting");
endmodule
`default_nettype wire

@@ rtl/core/python_def_class_scanner.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// python_def_class_scanner: finds class and def names in source text
// Front scanner feeds a one-entry job queue; back emitter streams names.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload
// in_ch     in   text_byte[8], end_of_text[1]
// out_ch    out  name_char[8], char_valid, is_class, start_line[24], last_char
//
// One input beat a cycle while no name is pending. When a line is accepted
// the input stalls until the emitter has read the line store, one beat per
// name character. Reset is synchronous and clears the scanner state, the
// queue flag and the emitter state machine; the line store is not cleared.
// ---------------------------------------------------------------------------
module python_def_class_scanner #(
  parameter int unsigned MAX_LINE  = 64,
  parameter int unsigned LINE_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  pdcs_if.sink     in_ch,
  pdcs_if.source   out_ch
);
  localparam int unsigned AW = $clog2(MAX_LINE);

  logic                 job_valid, job_ready, fr_job_valid;
  pdcs_pkg::job_t       fr_job, q_job;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [7:0]           wdata, rdata;
  logic                 q_full;
  logic                 in_ready_f;
  logic                 fire;
  logic                 accept_line;

  pdcs_front #(.MAX_LINE(MAX_LINE), .LINE_BITS(LINE_BITS)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ready_f),
    .in_byte(in_ch.data.text_byte), .in_eot(in_ch.data.end_of_text),
    .job_valid(fr_job_valid), .job(fr_job), .job_ready(!q_full && job_ready),
    .we, .waddr, .wdata
  );

  // Queue entry; the scanner is held while it or the emitter is busy.
  assign in_ch.ready = in_ready_f;
  assign fire = in_ch.valid && in_ch.ready;
  assign accept_line = fire && fr_job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_full <= 1'b0;
    end else if (accept_line) begin
      q_full <= 1'b1;
    end else if (job_valid && job_ready) begin
      q_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_line) begin
      q_job <= fr_job;
    end
  end
  assign job_valid = q_full;

  pdcs_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_store (
    .clk, .we(we && fire), .waddr, .wdata, .raddr, .rdata
  );

  pdcs_back #(.MAX_LINE(MAX_LINE)) u_back (
    .clk, .rst,
    .job_valid, .job(q_job), .job_ready,
    .raddr, .rdata,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .name_char(out_ch.data.name_char), .char_valid(out_ch.data.char_valid),
    .is_class(out_ch.data.is_class), .start_line(out_ch.data.start_line),
    .last_char(out_ch.data.last_char)
  );

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !in_ch.ready)
    else $error("input taken while a job is queued");
  a_line_queued: assert property (@(posedge clk) disable iff (rst)
    fr_job_valid && in_ch.ready |=> q_full)
    else $error("accepted line not queued");
  a_q_clear: assert property (@(posedge clk) disable iff (rst)
    q_full && job_ready |=> !q_full)
    else $error("queue entry not taken");
endmodule
`default_nettype wire

@@ bench/python_def_class_scanner_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// python_def_class_scanner_tb: self-checking bench of the definition scanner
// Streams directed and random source text into the scanner, predicts the
// name beats of every accepted class or def line and compares each output
// beat with the oldest prediction, under random stalls on both channels.
// ---------------------------------------------------------------------------
module python_def_class_scanner_tb;

  localparam int unsigned LINE_LIMIT = 64;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned CALM_TAIL = 40;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_beat_t;

  typedef struct packed {
    logic [7:0]  name_char;
    logic        char_valid;
    logic        is_class;
    logic [23:0] start_line;
    logic        last_char;
  } name_beat_t;

  logic clk;
  logic rst;
  pdcs_if #(.T(text_beat_t)) in_ch ();
  pdcs_if #(.T(name_beat_t)) out_ch ();

  python_def_class_scanner dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  text_beat_t pending_text[$];
  name_beat_t expected_names[$];
  bit         text_ready_to_go;
  int         failures;
  int unsigned driver_gap;
  int unsigned monitor_gap;
  int unsigned quiet_cycles;

  pdcs_pkg::scan_mode_t sc_mode;
  logic [2:0]      sc_kw;
  logic [1:0]      sc_quotes;
  logic [COUNT_BITS-1:0] sc_line;
  logic [7:0]      sc_store[LINE_LIMIT];
  logic [6:0]      sc_fill;
  logic [6:0]      sc_word_end;
  logic [6:0]      sc_colon;
  logic            sc_colon_seen;
  logic [COUNT_BITS-1:0] sc_def_line;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit blank_byte(logic [7:0] b);
    return b == 8'd32 || b == 8'd9 || b == 8'd13 || b == 8'd12 || b == 8'd11;
  endfunction

  function automatic bit word_byte(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == "_";
  endfunction

  function automatic bit header_byte(logic [7:0] b);
    return word_byte(b) || blank_byte(b) || b == "(" || b == ")" ||
           b == "," || b == "=";
  endfunction

  task automatic scanner_clear();
    sc_mode = pdcs_pkg::M_START;
    sc_kw = '0;
    sc_quotes = '0;
    sc_line = COUNT_BITS'(1);
    sc_fill = '0;
    sc_word_end = '0;
    sc_colon = '0;
    sc_colon_seen = 1'b0;
    sc_def_line = '0;
  endtask

  task automatic advance_line();
    if (sc_line != {COUNT_BITS{1'b1}}) sc_line = sc_line + 1'b1;
  endtask

  task automatic token_broken(logic [7:0] b);
    if (b == 8'd10) begin
      advance_line();
      sc_mode = pdcs_pkg::M_START;
    end else begin
      sc_mode = pdcs_pkg::M_SKIP;
    end
  endtask

  task automatic emit_names();
    int unsigned len;
    name_beat_t nb;
    bit cls;
    cls = (sc_mode == pdcs_pkg::M_BUF_CLASS);
    if (!sc_colon_seen) return;
    len = cls ? sc_word_end : sc_colon;
    if (len > LINE_LIMIT - 1) len = LINE_LIMIT - 1;
    nb.is_class = cls;
    nb.start_line = sc_def_line[23:0];
    if (len == 0) begin
      nb.name_char = 8'd0;
      nb.char_valid = 1'b0;
      nb.last_char = 1'b1;
      expected_names.push_back(nb);
      return;
    end
    for (int unsigned i = 0; i < len; i++) begin
      nb.name_char = sc_store[i];
      nb.char_valid = 1'b1;
      nb.last_char = (i + 1 == len);
      expected_names.push_back(nb);
    end
  endtask

  task automatic store_header_byte(logic [7:0] b);
    int unsigned i;
    i = sc_fill;
    if (i + 1 >= LINE_LIMIT) begin
      sc_mode = pdcs_pkg::M_SKIP;
      return;
    end
    sc_store[i] = b;
    sc_fill = 7'(i + 1);
    if (sc_colon_seen) return;
    if (sc_kw == 0) begin
      if (word_byte(b)) return;
      sc_kw = 3'd1;
      sc_word_end = 7'(i);
    end
    if (header_byte(b)) return;
    if (b == ":") begin
      sc_colon_seen = 1'b1;
      sc_colon = 7'(i);
      return;
    end
    sc_mode = pdcs_pkg::M_SKIP;
  endtask

  task automatic scan_text_byte(logic [7:0] b, bit eot);
    bit cls;
    int unsigned klen;
    logic [7:0] want;
    case (sc_mode)
      pdcs_pkg::M_START: begin
        if (b == 8'd10) begin
          advance_line();
          sc_mode = pdcs_pkg::M_START;
        end else if (blank_byte(b)) begin
          sc_mode = pdcs_pkg::M_START;
        end else if (b == "\"") begin
          sc_mode = pdcs_pkg::M_QOPEN;
          sc_quotes = 2'd1;
        end else if (b == "c") begin
          sc_mode = pdcs_pkg::M_KW_CLASS;
          sc_kw = 3'd1;
        end else if (b == "d") begin
          sc_mode = pdcs_pkg::M_KW_DEF;
          sc_kw = 3'd1;
        end else begin
          sc_mode = pdcs_pkg::M_SKIP;
        end
      end
      pdcs_pkg::M_SKIP: begin
        if (b == 8'd10) begin
          advance_line();
          sc_mode = pdcs_pkg::M_START;
        end
      end
      pdcs_pkg::M_QUOTE: begin
        if (b == "\"") begin
          if (sc_quotes >= 2) begin
            sc_quotes = 2'd0;
            sc_mode = pdcs_pkg::M_START;
          end else begin
            sc_quotes++;
          end
        end else begin
          sc_quotes = 2'd0;
          if (b == 8'd10) advance_line();
        end
      end
      pdcs_pkg::M_QOPEN: begin
        if (b == "\"") begin
          if (sc_quotes >= 2) begin
            sc_quotes = 2'd0;
            sc_mode = pdcs_pkg::M_QUOTE;
          end else begin
            sc_quotes++;
          end
        end else begin
          sc_quotes = 2'd0;
          token_broken(b);
        end
      end
      pdcs_pkg::M_KW_CLASS, pdcs_pkg::M_KW_DEF: begin
        cls = (sc_mode == pdcs_pkg::M_KW_CLASS);
        klen = cls ? 5 : 3;
        case (sc_kw)
          3'd1: want = cls ? "l" : "e";
          3'd2: want = cls ? "a" : "f";
          3'd3: want = "s";
          default: want = "s";
        endcase
        if (sc_kw >= klen) begin
          sc_kw = 3'd0;
          if (blank_byte(b)) sc_mode = cls ? pdcs_pkg::M_WS_CLASS : pdcs_pkg::M_WS_DEF;
          else token_broken(b);
        end else if (b == want) begin
          sc_kw++;
        end else begin
          sc_kw = 3'd0;
          token_broken(b);
        end
      end
      pdcs_pkg::M_WS_CLASS, pdcs_pkg::M_WS_DEF: begin
        if (b == 8'd10) begin
          advance_line();
          sc_mode = pdcs_pkg::M_START;
        end else if (!blank_byte(b)) begin
          sc_mode = (sc_mode == pdcs_pkg::M_WS_CLASS) ?
                    pdcs_pkg::M_BUF_CLASS : pdcs_pkg::M_BUF_DEF;
          sc_fill = '0;
          sc_word_end = '0;
          sc_colon = '0;
          sc_colon_seen = 1'b0;
          sc_kw = 3'd0;
          sc_def_line = sc_line;
          store_header_byte(b);
        end
      end
      pdcs_pkg::M_BUF_CLASS, pdcs_pkg::M_BUF_DEF: begin
        if (b == 8'd10) begin
          emit_names();
          advance_line();
          sc_mode = pdcs_pkg::M_START;
        end else begin
          store_header_byte(b);
        end
      end
      default: sc_mode = pdcs_pkg::M_START;
    endcase
    if (eot) begin
      if (sc_mode == pdcs_pkg::M_BUF_CLASS || sc_mode == pdcs_pkg::M_BUF_DEF) emit_names();
      scanner_clear();
    end
  endtask

  task automatic queue_byte(logic [7:0] b, bit eot);
    text_beat_t tb;
    tb.text_byte = b;
    tb.end_of_text = eot;
    pending_text.push_back(tb);
    scan_text_byte(b, eot);
  endtask

  task automatic queue_text(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] name_piece();
    case ($urandom_range(0, 9))
      0: return "_";
      1, 2: return 8'("0" + $urandom_range(0, 9));
      3, 4: return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] header_piece();
    case ($urandom_range(0, 11))
      0: return "(";
      1: return ")";
      2: return ",";
      3: return "=";
      4: return " ";
      5: return 8'd9;
      default: return name_piece();
    endcase
  endfunction

  task automatic queue_random_line();
    int unsigned kind;
    int unsigned n;
    bit eot;
    logic [7:0] b;
    eot = ($urandom_range(0, 14) == 0);
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) queue_byte($urandom_range(0, 1) ? 8'd32 : 8'd9, 1'b0);
    kind = $urandom_range(0, 19);
    if (kind < 16) begin
      if (kind < 8) queue_text("class", 1'b0);
      else queue_text("def", 1'b0);
      if ($urandom_range(0, 9) == 0) queue_byte(name_piece(), 1'b0);
      else queue_byte($urandom_range(0, 1) ? 8'd32 : 8'd12, 1'b0);
      if ($urandom_range(0, 3) == 0) queue_byte(8'd32, 1'b0);
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) b = 8'($urandom_range(0, 255));
        else if (i < 3) b = name_piece();
        else b = header_piece();
        if (b == 8'd10) b = 8'd0;
        queue_byte(b, 1'b0);
      end
      if ($urandom_range(0, 7) != 0) queue_byte(":", 1'b0);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        if (b == 8'd10) b = "#";
        queue_byte(b, 1'b0);
      end
    end else if (kind == 16) begin
      queue_text("\"\"\"", 1'b0);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) queue_byte($urandom_range(0, 3) == 0 ? 8'd10 : name_piece(), 1'b0);
      queue_text("\"\"\"", 1'b0);
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        if (b == 8'd10) b = 8'd255;
        queue_byte(b, 1'b0);
      end
    end
    queue_byte(8'd10, eot);
  endtask

  task automatic fill_text();
    string long_line;
    long_line = "def ";
    for (int i = 0; i < 66; i++) long_line = {long_line, "x"};
    queue_text("class Foo(Base):\n", 1'b0);
    queue_text("def bar(a, b=1):\n", 1'b0);
    queue_text("def :\n", 1'b0);
    queue_text("class (x):\n", 1'b0);
    queue_text("classX:\n", 1'b0);
    queue_text("def\n", 1'b0);
    queue_text("def   \n", 1'b0);
    queue_text("# def a():\n", 1'b0);
    queue_text("\"\"\"def q():\n\"\"\"def after():\n", 1'b0);
    queue_text("\"\"x\n", 1'b0);
    queue_text({long_line, ":\n"}, 1'b0);
    queue_text("def n", 1'b0);
    queue_byte(8'd0, 1'b0);
    queue_text(":\n", 1'b0);
    queue_text("def a.b():\n", 1'b0);
    queue_byte(8'd255, 1'b0);
    queue_byte(8'd10, 1'b0);
    queue_text("\tclass\tZ_9 :", 1'b1);
    queue_text("def tail(", 1'b1);
    while (pending_text.size() < 310) queue_random_line();
    text_ready_to_go = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      driver_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(pending_text.pop_front());
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (driver_gap != 0) begin
        driver_gap <= driver_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_text.size() != 0 && text_ready_to_go) begin
        if (pending_text.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
          driver_gap <= $urandom_range(0, 6);
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_text[0];
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      monitor_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_names.size() == 0) begin
          $display("%0t: unexpected name beat %h", $time, out_ch.data);
          failures++;
        end else begin
          name_beat_t exp_nb;
          exp_nb = expected_names.pop_front();
          if (out_ch.data.name_char !== exp_nb.name_char)
            $display("%0t: name_char expected %0d actual %0d", $time,
                     exp_nb.name_char, out_ch.data.name_char);
          if (out_ch.data.char_valid !== exp_nb.char_valid)
            $display("%0t: char_valid expected %0d actual %0d", $time,
                     exp_nb.char_valid, out_ch.data.char_valid);
          if (out_ch.data.is_class !== exp_nb.is_class)
            $display("%0t: is_class expected %0d actual %0d", $time,
                     exp_nb.is_class, out_ch.data.is_class);
          if (out_ch.data.start_line !== exp_nb.start_line)
            $display("%0t: start_line expected %0d actual %0d", $time,
                     exp_nb.start_line, out_ch.data.start_line);
          if (out_ch.data.last_char !== exp_nb.last_char)
            $display("%0t: last_char expected %0d actual %0d", $time,
                     exp_nb.last_char, out_ch.data.last_char);
          if (out_ch.data !== exp_nb) failures++;
        end
      end
      if (monitor_gap != 0) begin
        monitor_gap <= monitor_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (pending_text.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        monitor_gap <= $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d beats still expected", $time,
                 expected_names.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    failures = 0;
    text_ready_to_go = 1'b0;
    scanner_clear();
    fill_text();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_text.size() != 0 || expected_names.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/pdcs_pkg.sv
rtl/core/pdcs_if.sv
rtl/core/pdcs_ram.sv
rtl/core/pdcs_front.sv
rtl/core/pdcs_back.sv
rtl/core/python_def_class_scanner.sv
bench/python_def_class_scanner_tb.sv
